// ===== hdl/angle_mode_pid_axis_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the angle mode PID axis.
// The checks compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ANGLE_MODE_PID_AXIS_DEFINES_SVH
`define ANGLE_MODE_PID_AXIS_DEFINES_SVH
`ifndef SYNTH
`define AMP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("angle_mode_pid_axis: assertion failed");
`define AMP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   `AMP_ASSERT(label, clk, rst, (ante) |-> (cons))
`define AMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   `AMP_ASSERT(label, clk, rst, (ante) |=> (cons))
`else
`define AMP_ASSERT(label, clk, rst, prop)
`define AMP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define AMP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/ampid_pkg.sv =====
// ----------------------------------------------------------------------------
// ampid_pkg
// Types, widths, register indexes and the microcode program of the PID axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ampid_pkg;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   localparam logic [CSR_IDX_W-1:0] REG_STICK_SCALE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STICK_CENTER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KP           = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KI           = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KD           = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_I        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_FLOOR   = 3'd6;

   // Datapath widths.
   localparam int FLD_W   = 16;   // stick, rate, gain and coefficient width
   localparam int MAXI_W  = 23;
   localparam int OFFS_W  = 17;
   localparam int TGT_W   = 20;
   localparam int ERR_W   = 21;
   localparam int DIF_W   = 22;
   localparam int INTEG_W = 24;
   localparam int ACC_W   = 42;
   localparam int MA_W    = 34;
   localparam int MB_W    = 17;
   localparam int PROD_W  = MA_W + MB_W;
   localparam int CORR_W  = 32;
   localparam int FRAC_SHIFT  = 12;  // Q4.12 stick scale
   localparam int GAIN_SHIFT  = 8;   // Q8.8 coefficients and gain

   // Sequencer.
   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;
   localparam step_type STEP_IDLE = 4'd0;

   typedef enum logic [2:0] {
      MA_OFFS,
      MA_ERR,
      MA_INTEG,
      MA_DIF,
      MA_ACC
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_SCALE,
      MB_KP,
      MB_KI,
      MB_KD,
      MB_GAIN
   } mul_b_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_NO_ITEM,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic       take_in;
      mul_a_type  mul_a;
      mul_b_type  mul_b;
      logic       ld_prod;
      logic       ld_err;
      logic       upd_state;
      acc_op_type acc_op;
      logic       ld_out;
   } ctl_type;

   typedef struct packed {
      cond_type cond;
      step_type target;
      logic     last;
      ctl_type  ctl;
   } ucode_type;

   localparam ctl_type CTL_NOP = '{
      take_in:   1'b0,
      mul_a:     MA_OFFS,
      mul_b:     MB_SCALE,
      ld_prod:   1'b0,
      ld_err:    1'b0,
      upd_state: 1'b0,
      acc_op:    ACC_HOLD,
      ld_out:    1'b0
   };

   // The control program. Step 0 waits for an enabled item; the last step
   // holds until the result register is free and then returns to step 0.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '{cond: COND_NONE, target: STEP_IDLE, last: 1'b0, ctl: CTL_NOP};
      case (step)
         4'd0: begin
            w.cond        = COND_NO_ITEM;
            w.target      = STEP_IDLE;
            w.ctl.take_in = 1'b1;
         end
         4'd1: begin
            w.ctl.mul_a   = MA_OFFS;
            w.ctl.mul_b   = MB_SCALE;
            w.ctl.ld_prod = 1'b1;
         end
         4'd2: begin
            w.ctl.ld_err = 1'b1;
         end
         4'd3: begin
            w.ctl.upd_state = 1'b1;
            w.ctl.mul_a     = MA_ERR;
            w.ctl.mul_b     = MB_KP;
            w.ctl.ld_prod   = 1'b1;
         end
         4'd4: begin
            w.ctl.acc_op  = ACC_LOAD;
            w.ctl.mul_a   = MA_INTEG;
            w.ctl.mul_b   = MB_KI;
            w.ctl.ld_prod = 1'b1;
         end
         4'd5: begin
            w.ctl.acc_op  = ACC_ADD;
            w.ctl.mul_a   = MA_DIF;
            w.ctl.mul_b   = MB_KD;
            w.ctl.ld_prod = 1'b1;
         end
         4'd6: begin
            w.ctl.acc_op = ACC_ADD;
         end
         4'd7: begin
            w.ctl.mul_a   = MA_ACC;
            w.ctl.mul_b   = MB_GAIN;
            w.ctl.ld_prod = 1'b1;
         end
         4'd8: begin
            w.cond       = COND_OUT_BUSY;
            w.target     = 4'd8;
            w.last       = 1'b1;
            w.ctl.ld_out = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/angle_mode_pid_axis.sv =====
// ----------------------------------------------------------------------------
// angle_mode_pid_axis: one axis of a stick-driven PID rate stabilizer.
// An enabled item runs the whole microcode program before rsp_tvalid shows it;
// a new item is taken only back at step 0, and a disabled item is dropped there.
// Reset (synchronous): configuration registers, last error and integrator clear to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "angle_mode_pid_axis_defines.svh"

// The axis is run by a short microcode program. A step counter fetches one
// control word per cycle from a constant table; the word selects the operands
// of a single shared 34 x 17 signed multiplier and the registers that load.
// The nine steps are: wait for an item, stick offset times scale, target and
// error, state update with the proportional product, then the integral and
// derivative products summed in an accumulator, the gain product, and the
// saturated result load. The single multiplier sets the cycle count.
//
// A disabled item (tuser low) is accepted and dropped with no change to the loop state.
// The result sits in an output register, so the last step only stalls when
// an earlier result is still waiting for its transfer.

module angle_mode_pid_axis (
   input  logic        clock,
   input  logic        reset,

   // Input items. tdata: stick_position [15:0], measured_rate [31:16],
   // loop_gain [47:32]. tuser: axis_enable.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [0:0]  req_tuser,

   // Results. tdata: correction [31:0]. tuser: stick_ignored.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic [0:0]  rsp_tuser,

   // Register writes: 0 stick_scale, 1 stick_center, 2 kp, 3 ki, 4 kd,
   // 5 max_i, 6 gain floor.
   input  logic                                 csr_we,
   input  logic [ampid_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ampid_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   ampid_pkg::ctl_type                   ctl;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 out_busy;
   logic                                 start;
   logic signed [ampid_pkg::CORR_W-1:0]  correction;

   // A result register still holding an untaken result blocks the final step.
   assign out_busy = rsp_valid_ff && !rsp_tready;

   // Only an enabled item starts the program; a disabled one is simply taken.
   assign start      = req_tvalid && req_tuser[0];
   assign req_tready = ctl.take_in;

   ampid_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_busy (out_busy),
      .ctl      (ctl)
   );

   ampid_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .load_in        (req_tvalid && ctl.take_in),
      .stick_position (req_tdata[15:0]),
      .measured_rate  (req_tdata[31:16]),
      .loop_gain      (req_tdata[47:32]),
      .ctl            (ctl),
      .correction     (correction)
   );

   // Output valid: set when the result is loaded, cleared by its transfer.
   always_comb begin
      if (ctl.ld_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = correction;
   assign rsp_tuser  = 1'b1;  // the stick is always replaced by the loop output

   // An enabled item keeps the block busy on the following cycle.
   `AMP_ASSERT_NEXT(a_busy_after_start, clock, reset, req_tvalid && req_tready && req_tuser[0], !req_tready)
   // A result is never loaded over one that is still waiting.
   `AMP_ASSERT_IMPL(a_no_overwrite, clock, reset, ctl.ld_out, !(rsp_tvalid && !rsp_tready))
   // A new result appears only through the load step of the program.
   `AMP_ASSERT_IMPL(a_valid_from_load, clock, reset, $rose(rsp_tvalid), $past(ctl.ld_out))
   // The result load and input acceptance never share a step.
   `AMP_ASSERT_IMPL(a_load_not_idle, clock, reset, ctl.ld_out, !req_tready)

endmodule

// ===== hdl/ampid_seq.sv =====
// ----------------------------------------------------------------------------
// ampid_seq
// Step counter and microcode fetch with conditional jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ampid_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               out_busy,
   output ampid_pkg::ctl_type ctl
);

   ampid_pkg::step_type  step_ff;
   ampid_pkg::step_type  step_in;
   ampid_pkg::ucode_type word;
   logic                 cond_met;

   assign word = ampid_pkg::ucode_rom(step_ff);

   // Next step.
   always_comb begin
      case (word.cond)
         ampid_pkg::COND_NO_ITEM:  cond_met = !start;
         ampid_pkg::COND_OUT_BUSY: cond_met = out_busy;
         default:                  cond_met = 1'b0;
      endcase
      if (cond_met) begin
         step_in = word.target;
      end else if (word.last) begin
         step_in = ampid_pkg::STEP_IDLE;
      end else begin
         step_in = step_ff + ampid_pkg::STEP_W'(1);
      end
   end

   // Control outputs; the result load waits for a free result register.
   always_comb begin
      ctl        = word.ctl;
      ctl.ld_out = word.ctl.ld_out && !out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ampid_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== hdl/ampid_dp.sv =====
// ----------------------------------------------------------------------------
// ampid_dp
// Configuration registers, axis state and the shared multiply-accumulate path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ampid_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [ampid_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ampid_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                  load_in,
   input  logic [ampid_pkg::FLD_W-1:0]           stick_position,
   input  logic signed [ampid_pkg::FLD_W-1:0]    measured_rate,
   input  logic [ampid_pkg::FLD_W-1:0]           loop_gain,
   input  ampid_pkg::ctl_type                    ctl,
   output logic signed [ampid_pkg::CORR_W-1:0]   correction
);

   localparam int ISUM_W = ampid_pkg::INTEG_W + 1;
   localparam int OUTQ_W = ampid_pkg::PROD_W - ampid_pkg::GAIN_SHIFT;

   // Signed 32-bit limits, widened to the shifted product.
   localparam logic signed [OUTQ_W-1:0] OUTQ_MAX =
      {{(OUTQ_W - ampid_pkg::CORR_W + 1){1'b0}}, {(ampid_pkg::CORR_W-1){1'b1}}};
   localparam logic signed [OUTQ_W-1:0] OUTQ_MIN =
      {{(OUTQ_W - ampid_pkg::CORR_W + 1){1'b1}}, {(ampid_pkg::CORR_W-1){1'b0}}};

   // Configuration registers.
   logic signed [ampid_pkg::FLD_W-1:0]   scale_ff;
   logic [ampid_pkg::FLD_W-1:0]          center_ff;
   logic [ampid_pkg::FLD_W-1:0]          kp_ff;
   logic [ampid_pkg::FLD_W-1:0]          ki_ff;
   logic [ampid_pkg::FLD_W-1:0]          kd_ff;
   logic [ampid_pkg::MAXI_W-1:0]         max_i_ff;
   logic [ampid_pkg::FLD_W-1:0]          gain_floor_ff;

   // Captured item.
   logic [ampid_pkg::FLD_W-1:0]          stick_ff;
   logic signed [ampid_pkg::FLD_W-1:0]   rate_ff;
   logic [ampid_pkg::FLD_W-1:0]          gain_ff;

   // Axis state and working registers.
   logic signed [ampid_pkg::ERR_W-1:0]   last_err_ff, last_err_in;
   logic signed [ampid_pkg::INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ampid_pkg::ERR_W-1:0]   err_ff, err_in;
   logic signed [ampid_pkg::DIF_W-1:0]   dif_ff, dif_in;
   logic signed [ampid_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ampid_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ampid_pkg::CORR_W-1:0]  corr_ff, corr_in;

   logic signed [ampid_pkg::OFFS_W-1:0]  offs;
   logic signed [ampid_pkg::MA_W-1:0]    mul_a_v;
   logic signed [ampid_pkg::MB_W-1:0]    mul_b_v;
   logic [ampid_pkg::FLD_W-1:0]          gain_sel;
   logic signed [ampid_pkg::ERR_W-1:0]   tgt_raw;
   logic signed [ampid_pkg::TGT_W-1:0]   tgt;
   logic signed [ISUM_W-1:0]             isum;
   logic signed [ISUM_W-1:0]             lim;
   logic signed [ISUM_W-1:0]             isum_clamped;
   logic signed [OUTQ_W-1:0]             outq;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= '0;
         center_ff     <= '0;
         kp_ff         <= '0;
         ki_ff         <= '0;
         kd_ff         <= '0;
         max_i_ff      <= '0;
         gain_floor_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            ampid_pkg::REG_STICK_SCALE:  scale_ff      <= csr_wdata[ampid_pkg::FLD_W-1:0];
            ampid_pkg::REG_STICK_CENTER: center_ff     <= csr_wdata[ampid_pkg::FLD_W-1:0];
            ampid_pkg::REG_KP:           kp_ff         <= csr_wdata[ampid_pkg::FLD_W-1:0];
            ampid_pkg::REG_KI:           ki_ff         <= csr_wdata[ampid_pkg::FLD_W-1:0];
            ampid_pkg::REG_KD:           kd_ff         <= csr_wdata[ampid_pkg::FLD_W-1:0];
            ampid_pkg::REG_MAX_I:        max_i_ff      <= csr_wdata[ampid_pkg::MAXI_W-1:0];
            ampid_pkg::REG_GAIN_FLOOR:   gain_floor_ff <= csr_wdata[ampid_pkg::FLD_W-1:0];
            default: ;
         endcase
      end
   end

   assign offs     = $signed({1'b0, stick_ff}) - $signed({1'b0, center_ff});
   assign gain_sel = (gain_ff < gain_floor_ff) ? gain_floor_ff : gain_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      case (ctl.mul_a)
         ampid_pkg::MA_OFFS:  mul_a_v = ampid_pkg::MA_W'(offs);
         ampid_pkg::MA_ERR:   mul_a_v = ampid_pkg::MA_W'(err_ff);
         ampid_pkg::MA_INTEG: mul_a_v = ampid_pkg::MA_W'(integ_ff);
         ampid_pkg::MA_DIF:   mul_a_v = ampid_pkg::MA_W'(dif_ff);
         ampid_pkg::MA_ACC:   mul_a_v = acc_ff[ampid_pkg::ACC_W-1:ampid_pkg::GAIN_SHIFT];
         default:             mul_a_v = '0;
      endcase
      case (ctl.mul_b)
         ampid_pkg::MB_SCALE: mul_b_v = ampid_pkg::MB_W'(scale_ff);
         ampid_pkg::MB_KP:    mul_b_v = $signed({1'b0, kp_ff});
         ampid_pkg::MB_KI:    mul_b_v = $signed({1'b0, ki_ff});
         ampid_pkg::MB_KD:    mul_b_v = $signed({1'b0, kd_ff});
         ampid_pkg::MB_GAIN:  mul_b_v = $signed({1'b0, gain_sel});
         default:             mul_b_v = '0;
      endcase
   end

   assign prod_in = mul_a_v * mul_b_v;

   // Target rate: Q4.12 product shifted down, saturated to 20 bits.
   assign tgt_raw = prod_ff[ampid_pkg::FRAC_SHIFT + ampid_pkg::ERR_W - 1:ampid_pkg::FRAC_SHIFT];

   always_comb begin
      if (tgt_raw[ampid_pkg::ERR_W-1] != tgt_raw[ampid_pkg::TGT_W-1]) begin
         tgt = tgt_raw[ampid_pkg::ERR_W-1] ?
               {1'b1, {(ampid_pkg::TGT_W-1){1'b0}}} :
               {1'b0, {(ampid_pkg::TGT_W-1){1'b1}}};
      end else begin
         tgt = tgt_raw[ampid_pkg::TGT_W-1:0];
      end
   end

   assign err_in      = ampid_pkg::ERR_W'(tgt) - ampid_pkg::ERR_W'(rate_ff);
   assign dif_in      = ampid_pkg::DIF_W'(err_ff) - ampid_pkg::DIF_W'(last_err_ff);
   assign last_err_in = err_ff;

   // Integrator with symmetric clamp.
   assign isum = ISUM_W'(integ_ff) + ISUM_W'(err_ff);
   assign lim  = $signed({{(ISUM_W - ampid_pkg::MAXI_W){1'b0}}, max_i_ff});

   always_comb begin
      if (isum > lim) begin
         isum_clamped = lim;
      end else if (isum < -lim) begin
         isum_clamped = -lim;
      end else begin
         isum_clamped = isum;
      end
   end

   assign integ_in = isum_clamped[ampid_pkg::INTEG_W-1:0];

   always_comb begin
      case (ctl.acc_op)
         ampid_pkg::ACC_LOAD: acc_in = prod_ff[ampid_pkg::ACC_W-1:0];
         ampid_pkg::ACC_ADD:  acc_in = acc_ff + prod_ff[ampid_pkg::ACC_W-1:0];
         default:             acc_in = acc_ff;
      endcase
   end

   // Final shift by the gain fraction and saturation to 32 bits.
   assign outq = prod_ff[ampid_pkg::PROD_W-1:ampid_pkg::GAIN_SHIFT];

   always_comb begin
      if (outq > OUTQ_MAX) begin
         corr_in = {1'b0, {(ampid_pkg::CORR_W-1){1'b1}}};
      end else if (outq < OUTQ_MIN) begin
         corr_in = {1'b1, {(ampid_pkg::CORR_W-1){1'b0}}};
      end else begin
         corr_in = outq[ampid_pkg::CORR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
         integ_ff    <= '0;
      end else if (ctl.upd_state) begin
         last_err_ff <= last_err_in;
         integ_ff    <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         stick_ff <= stick_position;
         rate_ff  <= measured_rate;
         gain_ff  <= loop_gain;
      end
      if (ctl.ld_prod) begin
         prod_ff <= prod_in;
      end
      if (ctl.ld_err) begin
         err_ff <= err_in;
      end
      if (ctl.upd_state) begin
         dif_ff <= dif_in;
      end
      acc_ff <= acc_in;
      if (ctl.ld_out) begin
         corr_ff <= corr_in;
      end
   end

   assign correction = corr_ff;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the angle mode PID axis
// Drives stick, rate and gain items through the stream input under several
// register settings, predicts every correction with a local integer model of
// the axis, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   // Index that decodes to no register; writes to it must be ignored.
   localparam logic [ampid_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   // Cycles to let the block finish a dropped item before the registers
   // change, and after the last result at the end of the run.
   localparam int SETTLE_CYCLES = 12;
   // Cycles without any transfer or register write before the run is abandoned.
   localparam int QUIET_LIMIT = 1000;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 95;

   typedef struct {
      logic        enable;
      logic [15:0] stick;
      logic [15:0] rate;
      logic [15:0] gain;
   } axis_item_type;

   typedef struct {
      logic [31:0] correction;
      logic        stick_ignored;
   } axis_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic                             csr_we = 1'b0;
   logic [ampid_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ampid_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   angle_mode_pid_axis uut (
      .clock      (clock),
      .reset      (reset),
      // tdata: stick_position [15:0], measured_rate [31:16], loop_gain [47:32]
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      // tuser: axis_enable [0]
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // tdata: correction [31:0]
      .rsp_tdata  (rsp_tdata),
      // tuser: stick_ignored [0]
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Items waiting to be offered, and corrections waiting to come back.
   axis_item_type   stick_items[$];
   axis_result_type corr_expected[$];

   // Local copy of the register file, as the block should hold it.
   logic [15:0] cfg_scale      = '0;
   logic [15:0] cfg_center     = '0;
   logic [15:0] cfg_kp         = '0;
   logic [15:0] cfg_ki         = '0;
   logic [15:0] cfg_kd         = '0;
   logic [22:0] cfg_max_i      = '0;
   logic [15:0] cfg_gain_floor = '0;

   // Loop state: error of the previous enabled step and the clamped integral.
   longint prev_error = 0;
   longint integral   = 0;

   int err_count   = 0;
   int n_accepted  = 0;
   int n_enabled   = 0;
   int n_checked   = 0;
   int n_settings  = 0;
   bit sender_steady = 1'b0;

   function automatic longint clamp64(input longint x, input longint lo, input longint hi);
      if (x > hi)
         return hi;
      if (x < lo)
         return lo;
      return x;
   endfunction

   // One enabled control step: stick offset to target rate, error against the
   // measured rate, integral and derivative update, then the gain-scaled sum.
   // All shifts on signed values are arithmetic, so they round toward minus
   // infinity just as the hardware does.
   function automatic axis_result_type pid_correction(input axis_item_type it);
      longint offs, target, err, dif, g, sum, corr;
      axis_result_type r;
      offs   = longint'(it.stick) - longint'(cfg_center);
      target = (offs * longint'($signed(cfg_scale))) >>> ampid_pkg::FRAC_SHIFT;
      target = clamp64(target, -(64'sd1 <<< 19), (64'sd1 <<< 19) - 1);
      err    = target - longint'($signed(it.rate));
      dif    = err - prev_error;
      prev_error = err;
      // The integral clamp is symmetric; a zero limit pins it at zero.
      integral = clamp64(integral + err, -longint'(cfg_max_i), longint'(cfg_max_i));
      g = (it.gain < cfg_gain_floor) ? longint'(cfg_gain_floor) : longint'(it.gain);
      sum  = err * longint'(cfg_kp) + integral * longint'(cfg_ki) + dif * longint'(cfg_kd);
      corr = ((sum >>> ampid_pkg::GAIN_SHIFT) * g) >>> ampid_pkg::GAIN_SHIFT;
      corr = clamp64(corr, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
      r.correction    = corr[31:0];
      r.stick_ignored = 1'b1;
      return r;
   endfunction

   // Register write for one cycle. The unused upper bits of the narrow
   // registers carry random junk, which the block must ignore.
   task automatic csr_write(input logic [ampid_pkg::CSR_IDX_W-1:0] idx,
                            input logic [22:0] val);
      logic [22:0] data;
      data = (idx == ampid_pkg::REG_MAX_I) ? val : {7'($urandom()), val[15:0]};
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         ampid_pkg::REG_STICK_SCALE:  cfg_scale      = data[15:0];
         ampid_pkg::REG_STICK_CENTER: cfg_center     = data[15:0];
         ampid_pkg::REG_KP:           cfg_kp         = data[15:0];
         ampid_pkg::REG_KI:           cfg_ki         = data[15:0];
         ampid_pkg::REG_KD:           cfg_kd         = data[15:0];
         ampid_pkg::REG_MAX_I:        cfg_max_i      = data;
         ampid_pkg::REG_GAIN_FLOOR:   cfg_gain_floor = data[15:0];
         default: ;
      endcase
   endtask

   // Load a whole register setting, plus one write to the unused index.
   task automatic load_setting(input logic [15:0] scale, input logic [15:0] center,
                               input logic [15:0] kp, input logic [15:0] ki,
                               input logic [15:0] kd, input logic [22:0] max_i,
                               input logic [15:0] gain_floor);
      csr_write(ampid_pkg::REG_STICK_SCALE, {7'd0, scale});
      csr_write(ampid_pkg::REG_STICK_CENTER, {7'd0, center});
      csr_write(ampid_pkg::REG_KP, {7'd0, kp});
      csr_write(REG_UNUSED, 23'($urandom()));
      csr_write(ampid_pkg::REG_KI, {7'd0, ki});
      csr_write(ampid_pkg::REG_KD, {7'd0, kd});
      csr_write(ampid_pkg::REG_MAX_I, max_i);
      csr_write(ampid_pkg::REG_GAIN_FLOOR, {7'd0, gain_floor});
      @(posedge clock);
      csr_we <= 1'b0;
      n_settings++;
   endtask

   task automatic add_item(input logic en, input logic [15:0] stick,
                           input logic [15:0] rate, input logic [15:0] gain);
      axis_item_type it;
      it.enable = en;
      it.stick  = stick;
      it.rate   = rate;
      it.gain   = gain;
      stick_items.push_back(it);
   endtask

   // Wait until every item has been taken and every correction has come back,
   // then give a dropped item time to leave the pipeline.
   task automatic wait_drained();
      while (stick_items.size() != 0 || req_tvalid || corr_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A coefficient that is often an extreme and otherwise spread over every
   // magnitude, so that products neither always saturate nor vanish.
   function automatic logic [15:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
      endcase
   endfunction

   function automatic logic [15:0] pick_scale();
      logic [15:0] s;
      case ($urandom_range(0, 5))
         0: s = 16'h8000;
         1: s = 16'h7FFF;
         default: begin
            s = 16'($urandom_range(0, 32767) >> $urandom_range(0, 14));
            if ($urandom_range(0, 1) == 1)
               s = -s;
         end
      endcase
      return s;
   endfunction

   // Random stream for one setting. Most items are enabled control steps, often
   // with the stick near its center or moderate rates, so the integral builds up
   // and reaches its clamp; a share is full-range noise and disabled items.
   // Runs of a repeated item hold the error steady so the derivative drops out.
   task automatic add_random_items(input int count);
      axis_item_type it;
      int reps;
      int k;
      k = 0;
      while (k < count) begin
         it.enable = ($urandom_range(0, 99) < 85);
         if ($urandom_range(0, 1) == 1)
            it.stick = cfg_center + 16'($signed($urandom_range(0, 4000)) - 2000);
         else
            it.stick = 16'($urandom());
         if ($urandom_range(0, 1) == 1)
            it.rate = 16'($urandom());
         else
            it.rate = 16'($signed($urandom_range(0, 2000)) - 1000);
         if ($urandom_range(0, 3) == 0)
            it.gain = 16'($urandom_range(0, 512));
         else
            it.gain = 16'($urandom());
         reps = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 6) : 1;
         repeat (reps) begin
            stick_items.push_back(it);
            if (it.enable)
               k++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Input driver. Items go out in bursts of random length separated by random
   // gaps; a phase may also run with no gaps at all. An offered item is held
   // until its transfer, and the prediction is made at the transfer itself.
   // ------------------------------------------------------------------------
   axis_item_type cur_item;
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            n_accepted++;
            if (cur_item.enable) begin
               n_enabled++;
               corr_expected.push_back(pid_correction(cur_item));
            end
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (stick_items.size() != 0) begin
               cur_item = stick_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_item.gain, cur_item.rate, cur_item.stick};
               req_tuser  <= cur_item.enable;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  if (sender_steady || $urandom_range(0, 3) == 0)
                     gap_left = 0;
                  else
                     gap_left = $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor. Each result transfer is checked against the oldest
   // expected correction. Readiness follows a pattern, picked by the top bits of
   // a free-running counter, that switches between always ready, random stalls,
   // a short periodic stall and long stall stretches, so results meet back-pressure.
   // ------------------------------------------------------------------------
   axis_result_type exp_result;
   logic [9:0]      stall_cyc = '0;
   logic            ready_next;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (corr_expected.size() == 0) begin
            $error("result transfer with nothing expected: correction %0d",
                   $signed(rsp_tdata));
            err_count++;
         end else begin
            exp_result = corr_expected.pop_front();
            n_checked++;
            if (rsp_tdata !== exp_result.correction) begin
               $error("correction: expected %0d, got %0d",
                      $signed(exp_result.correction), $signed(rsp_tdata));
               err_count++;
            end
            if (rsp_tuser[0] !== exp_result.stick_ignored) begin
               $error("stick_ignored: expected %0b, got %0b",
                      exp_result.stick_ignored, rsp_tuser[0]);
               err_count++;
            end
         end
      end
      stall_cyc <= stall_cyc + 10'd1;
      case (stall_cyc[9:8])
         2'd0: ready_next = 1'b1;
         2'd1: ready_next = ($urandom_range(0, 9) >= 4);
         2'd2: ready_next = (stall_cyc[2:0] < 3'd3);
         default: ready_next = (stall_cyc[4:0] >= 5'd14);
      endcase
      rsp_tready <= ready_next;
   end

   // ------------------------------------------------------------------------
   // Watchdog: the run is abandoned when nothing moves for too long.
   // ------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog expired: no transfer for %0d cycles", QUIET_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: reset, a directed part under hand-picked settings, then random
   // phases, each under a fresh register setting written while idle.
   // ------------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers straight out of reset are all zero, so the correction is 0.
      add_item(1'b1, 16'hFFFF, 16'h8000, 16'hFFFF);
      add_item(1'b1, 16'h0000, 16'h7FFF, 16'h0000);
      wait_drained();

      // Largest positive scale around mid stick; gain below the floor,
      // disabled items between enabled ones, and a repeated item with no
      // derivative. The small integral limit is hit within two steps.
      load_setting(16'h7FFF, 16'h8000, 16'h0100, 16'h0040, 16'h0200, 23'd1000, 16'h0080);
      add_item(1'b1, 16'hFFFF, 16'h8000, 16'hFFFF);
      add_item(1'b1, 16'h0000, 16'h7FFF, 16'h0000);
      add_item(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_item(1'b1, 16'h8000, 16'h0000, 16'h0100);
      add_item(1'b1, 16'h8000, 16'h0000, 16'h0100);
      add_item(1'b0, 16'h0000, 16'h0000, 16'h0000);
      add_item(1'b1, 16'hFFFF, 16'h7FFF, 16'h0050);
      add_item(1'b1, 16'h8001, 16'hFFFF, 16'h8000);
      wait_drained();

      // Most negative scale with full coefficients: the correction runs into
      // both saturation limits. A zero integral limit keeps the integral at zero.
      load_setting(16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 23'd0, 16'hFFFF);
      add_item(1'b1, 16'hFFFF, 16'h8000, 16'h0000);
      add_item(1'b1, 16'h0000, 16'h8000, 16'hFFFF);
      add_item(1'b1, 16'h0000, 16'h7FFF, 16'h1234);
      add_item(1'b0, 16'h5555, 16'hAAAA, 16'h5555);
      add_item(1'b1, 16'hFFFF, 16'h0001, 16'h0000);
      wait_drained();

      // Zero scale, top center and the largest integral limit: only the
      // measured rate drives the loop, so the integral can grow unchecked.
      load_setting(16'h0000, 16'hFFFF, 16'h0001, 16'h0100, 16'h0000, 23'h7FFFFF, 16'h0000);
      add_item(1'b1, 16'h1234, 16'h8000, 16'hFFFF);
      add_item(1'b1, 16'hFFFF, 16'h8000, 16'hFFFF);
      add_item(1'b1, 16'h0000, 16'h7FFF, 16'h0001);
      add_item(1'b1, 16'hAAAA, 16'h0000, 16'h0000);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         sender_steady = (p % 3 == 2);
         load_setting(pick_scale(), 16'($urandom()), pick_coef(), pick_coef(), pick_coef(),
                      23'($urandom_range(0, 8388607) >> $urandom_range(0, 22)),
                      ($urandom_range(0, 1) == 1) ? pick_coef() : 16'h0000);
         add_random_items(ITEMS_PER_PHASE);
         wait_drained();
      end

      $display("Run covered %0d input transfers (%0d enabled) over %0d register settings.",
               n_accepted, n_enabled, n_settings);
      $display("%0d corrections were checked against the predicted values.", n_checked);
      if (err_count == 0 && corr_expected.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ampid_pkg.sv
hdl/ampid_seq.sv
hdl/ampid_dp.sv
hdl/angle_mode_pid_axis.sv
tb/tb.sv
